FILE: hw/rtl/ffsa_pkg.sv
// shared types and constants for the first-fit segment allocator
`default_nettype none
package ffsa_pkg;
    localparam int unsigned MaxSegments = 64;
    localparam int unsigned AddrWidth   = 32;
    localparam int unsigned HandleWidth = 16;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOSPACE = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_DUP     = 3'd4;

    localparam logic CFG_MEMORY_SIZE = 1'b0;
    localparam logic CFG_ALIGN_LOG2  = 1'b1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic shift_step;
        logic commit;
        logic fail;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic error;
    } t_sts;
endpackage
`default_nettype wire

FILE: hw/rtl/ffsa_ctrl.sv
// controller state machine for the first-fit segment allocator
`default_nettype none
module ffsa_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    input  ffsa_pkg::t_sts  i_sts,
    output ffsa_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_OUT} t_state;
    t_state r_state;
    logic   r_out_valid;

    assign o_out_valid = r_out_valid;
    // a waiting result holds off the next request so its payload stays put
    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:   o_cmd.load = i_in_valid && !r_out_valid;
            S_SCAN:   o_cmd.scan_step = 1'b1;
            S_DECIDE: begin
                o_cmd.fail = i_sts.error;
            end
            S_SHIFT:  begin
                o_cmd.shift_step = ~i_sts.shift_done;
                o_cmd.commit     = i_sts.shift_done;
            end
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE:   if (i_in_valid && !r_out_valid) r_state <= S_SCAN;
                S_SCAN:   if (i_sts.scan_done) r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (i_sts.error) r_state <= S_OUT;
                    else             r_state <= S_SHIFT;
                end
                S_SHIFT:  if (i_sts.shift_done) r_state <= S_OUT;
                S_OUT:    if (!r_out_valid || !i_out_stall) begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/ffsa_dp.sv
// datapath with segment table memories, scan and shift logic and statistics
`default_nettype none
module ffsa_dp #(
    parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MaxSegments
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_index,
    input  wire  [31:0]           i_cfg_data,
    input  wire                   i_kind,
    input  wire  [31:0]           i_req_size,
    input  wire  [15:0]           i_buf_handle,
    input  ffsa_pkg::t_cmd        i_cmd,
    output ffsa_pkg::t_sts        o_sts,
    output logic [2:0]            o_status,
    output logic [31:0]           o_address,
    output logic [31:0]           o_live_bytes,
    output logic [31:0]           o_peak_used,
    output logic [31:0]           o_peak_live
);
    localparam int unsigned IW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned AW = ffsa_pkg::AddrWidth;
    localparam int unsigned HW = ffsa_pkg::HandleWidth;

    logic [AW-1:0] r_mem_begin [MAX_SEGMENTS];
    logic [AW-1:0] r_mem_end   [MAX_SEGMENTS];
    logic [HW-1:0] r_mem_owner [MAX_SEGMENTS];

    logic [31:0]   r_memory_size;
    logic [3:0]    r_align_log2;
    logic [CW-1:0] r_count;
    logic [31:0]   r_live_total, r_used_peak, r_live_peak;

    logic          r_kind;
    logic [HW-1:0] r_handle;
    logic [AW:0]   r_seg;
    logic [CW-1:0] r_idx;
    logic          r_rd_valid;
    logic [AW-1:0] r_rd_begin, r_rd_end;
    logic [HW-1:0] r_rd_owner;
    logic [AW-1:0] r_prev;
    logic          r_found_pos, r_found_own;
    logic [CW-1:0] r_pos, r_own;
    logic [AW-1:0] r_own_begin, r_own_end;
    logic [CW-1:0] r_sh;
    logic          r_wb_valid;
    logic [IW-1:0] r_wb_addr;
    logic [AW-1:0] r_wb_begin, r_wb_end;
    logic [HW-1:0] r_wb_owner;
    logic [2:0]    r_status;
    logic [31:0]   r_address;
    logic [AW-1:0] r_new_begin;
    logic          r_ins_pend;
    logic [IW-1:0] r_ins_addr;
    logic [AW-1:0] r_ins_end;

    logic [AW:0]   n_seg;
    logic [32:0]   w_sz;
    logic [AW:0]   w_unit;
    logic [AW:0]   w_tail_end;
    logic          w_gap_fit;
    logic          w_alloc;
    logic [2:0]    w_err;
    logic [CW-1:0] w_sh_next;
    logic [IW-1:0] w_rd_addr;
    logic [AW-1:0] w_seg_a;
    logic [31:0]   w_delta;

    assign w_alloc = (r_kind == ffsa_pkg::KIND_ALLOC);
    assign w_sz    = (i_req_size == 32'd0) ? 33'd1 : {1'b0, i_req_size};
    assign w_unit  = (AW + 1)'(1) << r_align_log2;
    always_comb begin
        n_seg = ((AW + 1)'(w_sz) + w_unit - (AW + 1)'(1)) >> r_align_log2;
        n_seg = n_seg << r_align_log2;
    end
    assign w_seg_a    = r_seg[AW-1:0];
    assign w_gap_fit  = r_rd_valid && !r_found_pos
                        && ({1'b0, r_rd_begin - r_prev} >= r_seg);
    assign w_tail_end = {1'b0, r_prev} + r_seg;

    always_comb begin
        w_err = ffsa_pkg::ST_OK;
        if (w_alloc) begin
            if (r_found_own)                         w_err = ffsa_pkg::ST_DUP;
            else if (r_count >= CW'(MAX_SEGMENTS))   w_err = ffsa_pkg::ST_FULL;
            else if (!r_found_pos && (w_tail_end[AW] || ((r_memory_size != 32'd0)
                     && (AW'(w_tail_end) > AW'(r_memory_size)))))
                                                     w_err = ffsa_pkg::ST_NOSPACE;
        end else if (!r_found_own)                   w_err = ffsa_pkg::ST_UNKNOWN;
    end

    assign o_sts.scan_done  = (r_idx >= r_count) && !r_rd_valid;
    assign o_sts.error      = (w_err != ffsa_pkg::ST_OK);
    assign o_sts.shift_done = w_alloc ? (r_sh <= (r_found_pos ? r_pos : r_count))
                                      : (r_sh + CW'(1) >= r_count);
    assign w_sh_next = w_alloc ? r_sh - CW'(1) : r_sh + CW'(1);
    always_comb begin
        if (i_cmd.shift_step) w_rd_addr = IW'(w_alloc ? r_sh - CW'(1) : r_sh + CW'(1));
        else                  w_rd_addr = IW'(r_idx);
    end
    assign w_delta = 32'(w_alloc ? w_seg_a : r_own_end - r_own_begin);

    always_ff @(posedge i_clk) begin
        r_rd_begin <= r_mem_begin[w_rd_addr];
        r_rd_end   <= r_mem_end[w_rd_addr];
        r_rd_owner <= r_mem_owner[w_rd_addr];
        if (r_wb_valid) begin
            r_mem_begin[r_wb_addr] <= r_wb_begin;
            r_mem_end[r_wb_addr]   <= r_wb_end;
            r_mem_owner[r_wb_addr] <= r_wb_owner;
        end
        if (r_ins_pend) begin
            r_mem_begin[r_ins_addr] <= r_new_begin;
            r_mem_end[r_ins_addr]   <= r_ins_end;
            r_mem_owner[r_ins_addr] <= r_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_memory_size <= 32'd0;
            r_align_log2  <= 4'd6;
            r_count       <= '0;
            r_live_total  <= 32'd0;
            r_used_peak   <= 32'd0;
            r_live_peak   <= 32'd0;
            r_rd_valid    <= 1'b0;
            r_wb_valid    <= 1'b0;
            r_idx         <= '0;
        end else begin
            r_wb_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == ffsa_pkg::CFG_MEMORY_SIZE) r_memory_size <= i_cfg_data;
                else                                          r_align_log2 <= i_cfg_data[3:0];
            end
            if (i_cmd.load) begin
                r_kind      <= i_kind;
                r_handle    <= HW'(i_buf_handle);
                r_seg       <= n_seg;
                r_idx       <= '0;
                r_rd_valid  <= 1'b0;
                r_prev      <= '0;
                r_found_pos <= 1'b0;
                r_found_own <= 1'b0;
                r_pos       <= '0;
                r_own       <= '0;
            end
            if (i_cmd.scan_step) begin
                r_rd_valid <= (r_idx < r_count);
                if (r_idx < r_count) r_idx <= r_idx + CW'(1);
                if (r_rd_valid) begin
                    if (r_rd_owner == r_handle && !r_found_own) begin
                        r_found_own <= 1'b1;
                        r_own       <= r_idx - CW'(1);
                        r_own_begin <= r_rd_begin;
                        r_own_end   <= r_rd_end;
                    end
                    if (w_gap_fit) begin
                        r_found_pos <= 1'b1;
                        r_pos       <= r_idx - CW'(1);
                    end else if (!r_found_pos) begin
                        r_prev <= r_rd_end;
                    end
                end
            end
            if (o_sts.scan_done && i_cmd.scan_step) begin
                r_sh       <= w_alloc ? r_count : r_own;
                r_rd_valid <= 1'b0;
            end
            if (i_cmd.fail) begin
                r_status  <= w_err;
                r_address <= 32'd0;
            end
            if (i_cmd.shift_step) begin
                r_rd_valid <= 1'b1;
                r_sh       <= w_sh_next;
                if (r_rd_valid) begin
                    r_wb_valid <= 1'b1;
                    r_wb_addr  <= IW'(w_alloc ? r_sh + CW'(1) : r_sh - CW'(1));
                    r_wb_begin <= r_rd_begin;
                    r_wb_end   <= r_rd_end;
                    r_wb_owner <= r_rd_owner;
                end
            end
            if (i_cmd.commit) begin
                r_status   <= ffsa_pkg::ST_OK;
                r_rd_valid <= 1'b0;
                if (r_rd_valid) begin
                    r_wb_valid <= 1'b1;
                    r_wb_addr  <= IW'(w_alloc ? r_sh + CW'(1) : r_sh - CW'(1));
                    r_wb_begin <= r_rd_begin;
                    r_wb_end   <= r_rd_end;
                    r_wb_owner <= r_rd_owner;
                end
                if (w_alloc) begin
                    r_new_begin <= r_prev;
                    r_address   <= 32'(r_prev);
                    r_count     <= r_count + CW'(1);
                    r_live_total <= r_live_total + w_delta;
                    if (32'(r_prev + w_seg_a) > r_used_peak)
                        r_used_peak <= 32'(r_prev + w_seg_a);
                    if (r_live_total + w_delta > r_live_peak)
                        r_live_peak <= r_live_total + w_delta;
                end else begin
                    r_address    <= 32'(r_own_begin);
                    r_count      <= r_count - CW'(1);
                    r_live_total <= r_live_total - w_delta;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins_pend <= 1'b0;
        end else begin
            r_ins_pend <= i_cmd.commit && w_alloc;
            if (i_cmd.commit) begin
                r_ins_addr <= IW'(r_sh);
                r_ins_end  <= r_prev + w_seg_a;
            end
        end
    end

    assign o_status     = r_status;
    assign o_address    = r_address;
    assign o_live_bytes = r_live_total;
    assign o_peak_used  = r_used_peak;
    assign o_peak_live  = r_live_peak;
endmodule
`default_nettype wire

FILE: hw/rtl/first_fit_segment_allocator.sv
// top level of the first-fit segment allocator
// a request passes a scan of the table, a decide state, on success a table shift of one
// entry per cycle, then the output register
// throughput: one request at a time; the next is accepted no earlier than the cycle
// after the previous result transaction
// reset clears count, statistics, memory size; align_log2 to 6; table read only below count
`default_nettype none
module first_fit_segment_allocator #(
    parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MaxSegments
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_kind,
    input  wire  [31:0] i_req_size,
    input  wire  [15:0] i_buf_handle,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_address,
    output logic [31:0] o_live_bytes,
    output logic [31:0] o_peak_used,
    output logic [31:0] o_peak_live
);
    ffsa_pkg::t_cmd w_cmd;
    ffsa_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ffsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ffsa_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_kind),
        .i_req_size   (i_req_size),
        .i_buf_handle (i_buf_handle),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_status     (o_status),
        .o_address    (o_address),
        .o_live_bytes (o_live_bytes),
        .o_peak_used  (o_peak_used),
        .o_peak_live  (o_peak_live)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.scan_step, w_cmd.shift_step, w_cmd.commit, w_cmd.fail}))
        else $error("more than one datapath command");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !o_in_stall)
        else $error("load while busy");
    a_err_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ffsa_pkg::ST_OK) |-> (o_address == 32'd0))
        else $error("error result with nonzero address");
endmodule
`default_nettype wire
